FILE: rtl/pps_time_of_day_keeper_macros.svh
// Assertion macros used by the time-of-day keeper checker.
`ifndef PPS_TIME_OF_DAY_KEEPER_MACROS_SVH
`define PPS_TIME_OF_DAY_KEEPER_MACROS_SVH

// Clocked assertion, quiet while reset is low.
`define PTK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs through reset.
`define PTK_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ptk_pkg.sv
// Types, codes and constants of the time-of-day keeper.
`default_nettype none

package ptk_pkg;

    localparam int PTK_CYCLES_PER_SECOND = 32768;
    localparam int PTK_RATIO_FRAC_BITS   = 30;

    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CYC_W      = 32;
    localparam int SEC_W      = 32;
    localparam int US_W       = 20;
    localparam int RATIO_W    = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // delta * 1e6 and the elapsed microseconds both fit in 52 bits
    localparam int E_W       = 52;
    // corrected microseconds, up to E / 0.9
    localparam int Q_W       = 53;
    localparam int MUL_X_W   = 33;
    localparam int ACC_W     = 54;
    localparam int MUL_BIT_W = 5;
    localparam int MUL_BITS  = 20;

    localparam int DIV_DEN_W = 32;
    // covers E_W + RATIO_FRAC_BITS over the whole range of the fraction width
    localparam int DIV_CNT_W = 7;

    localparam logic [US_W-1:0]  US_PER_S        = 20'd1000000;
    localparam logic [CYC_W-1:0] DOUBLE_LIMIT_US = 32'd700000;
    localparam logic [CYC_W-1:0] MISSED_LIMIT_US = 32'd1100000;

    localparam logic [REQ_W-1:0] REQ_PULSE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DOUBLE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_SET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_SEC   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_DIV_C_GO,
        ST_DIV_C,
        ST_MUL_E,
        ST_DIV_R_GO,
        ST_DIV_R,
        ST_DIV_U_GO,
        ST_DIV_U,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/ptk_req_if.sv
// Request channel: pulse, set and query words.
`default_nettype none

interface ptk_req_if;
    logic                      valid;
    logic                      ready;
    logic [ptk_pkg::REQ_W-1:0] req_type;
    logic [ptk_pkg::CYC_W-1:0] cycle_count;
    logic [ptk_pkg::SEC_W-1:0] set_seconds;

    modport source (output valid, output req_type, output cycle_count,
                    output set_seconds, input ready);
    modport sink   (input valid, input req_type, input cycle_count,
                    input set_seconds, output ready);
endinterface

`default_nettype wire

FILE: rtl/ptk_rsp_if.sv
// Response channel: status and time words.
`default_nettype none

interface ptk_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ptk_pkg::STAT_W-1:0] status;
    logic                       missed_pulse;
    logic [ptk_pkg::SEC_W-1:0]  seconds;
    logic [ptk_pkg::US_W-1:0]   microseconds;

    modport source (output valid, output status, output missed_pulse,
                    output seconds, output microseconds, input ready);
    modport sink   (input valid, input status, input missed_pulse,
                    input seconds, input microseconds, output ready);
endinterface

`default_nettype wire

FILE: rtl/ptk_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module ptk_div #(
    parameter int NUM_W = ptk_pkg::E_W + ptk_pkg::PTK_RATIO_FRAC_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptk_pkg::t_div_req i_div,
    input  wire logic [NUM_W-1:0]  i_num,
    output ptk_pkg::t_div_rsp      o_div,
    output logic [NUM_W-1:0]       o_quo
);
    import ptk_pkg::*;

    logic [NUM_W-1:0]     r_sr;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   rem2;
    logic [DIV_DEN_W:0]   diff;
    logic                 qbit;

    // numerator is left-aligned; quotient bits fill in from the bottom
    assign rem2 = {r_rem, r_sr[NUM_W-1]};
    assign diff = rem2 - {1'b0, r_den};
    assign qbit = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_div.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_div.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_div.start) begin
            r_sr  <= i_num;
            r_rem <= '0;
            r_den <= i_div.den;
        end else if (r_busy) begin
            r_sr  <= {r_sr[NUM_W-2:0], qbit};
            r_rem <= qbit ? diff[DIV_DEN_W-1:0] : rem2[DIV_DEN_W-1:0];
        end
    end

    assign o_div.done = r_done;
    assign o_div.rem  = r_rem;
    assign o_quo      = r_sr;

endmodule

`default_nettype wire

FILE: rtl/pps_time_of_day_keeper.sv
// Time-of-day keeper: second counter stepped by RTC pulses, with corrected queries.
// One request word at a time. A set, an unused code or a query before the time is
// set goes straight to the result. A pulse runs a shift-add multiply of the cycle
// delta by 1e6, starts the divider, runs a bit-serial divide by CYCLES_PER_SECOND
// and then finishes. A valid query takes the same two steps, another shift-add
// multiply, a divide by the frequency ratio and a divide by 1e6, all on the one
// serial divider. A finished response word sits in the output register while the
// block takes the next request.
// Configuration writes are taken at any cycle with i_cfg_we high; a frequency ratio
// outside 0.9 to 1.1 is dropped.
`default_nettype none

module pps_time_of_day_keeper #(
    parameter int CYCLES_PER_SECOND = ptk_pkg::PTK_CYCLES_PER_SECOND,
    parameter int RATIO_FRAC_BITS   = ptk_pkg::PTK_RATIO_FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ptk_req_if.sink                              i_req,
    ptk_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [ptk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ptk_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ptk_pkg::*;

    localparam int NUM_W = E_W + RATIO_FRAC_BITS;

    localparam logic [E_W-1:0]       HALF_C   = E_W'(CYCLES_PER_SECOND / 2);
    localparam logic [DIV_DEN_W-1:0] DEN_C    = DIV_DEN_W'(CYCLES_PER_SECOND);
    localparam logic [RATIO_W-1:0]   RATIO_ONE = RATIO_W'(64'd1 << RATIO_FRAC_BITS);
    localparam logic [RATIO_W-1:0]   RATIO_LO =
        RATIO_W'(((64'd9 << RATIO_FRAC_BITS) + 64'd9) / 64'd10);
    localparam logic [RATIO_W-1:0]   RATIO_HI =
        RATIO_W'((64'd11 << RATIO_FRAC_BITS) / 64'd10);
    localparam logic [DIV_CNT_W-1:0] ITER_C   = DIV_CNT_W'(E_W);
    localparam logic [DIV_CNT_W-1:0] ITER_R   = DIV_CNT_W'(NUM_W);
    localparam logic [DIV_CNT_W-1:0] ITER_U   = DIV_CNT_W'(Q_W);
    localparam logic [MUL_BIT_W-1:0] MUL_TOP  = MUL_BIT_W'(MUL_BITS - 1);

    t_state r_state, n_state;

    // configuration and time state
    logic [RATIO_W-1:0] r_freq_ratio;
    logic [SEC_W-1:0]   r_corr_sec;
    logic [SEC_W-1:0]   r_sec_cnt;
    logic [CYC_W-1:0]   r_last_cyc;
    logic               r_time_valid;

    // working registers
    logic [REQ_W-1:0]     r_req;
    logic [CYC_W-1:0]     r_cyc;
    logic [MUL_X_W-1:0]   r_mul_x;
    logic [ACC_W-1:0]     r_acc;
    logic [MUL_BIT_W-1:0] r_bit;
    logic [CYC_W-1:0]     r_us;

    logic [STAT_W-1:0] r_res_status;
    logic              r_res_missed;
    logic [SEC_W-1:0]  r_res_sec;
    logic [US_W-1:0]   r_res_us;

    logic              r_o_valid;
    logic [STAT_W-1:0] r_o_status;
    logic              r_o_missed;
    logic [SEC_W-1:0]  r_o_sec;
    logic [US_W-1:0]   r_o_us;

    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quo;

    logic             in_acc;
    logic             out_load;
    logic             mul_step;
    logic [ACC_W-1:0] mul_next;
    logic [ACC_W-1:0] e_sum;
    logic [E_W-1:0]   e_val;
    logic [E_W-1:0]   c_num;
    logic [CYC_W-1:0] pulse_us;
    logic             pulse_done;
    logic [SEC_W-1:0] sec_next;

    assign i_req.ready = (r_state == ST_IDLE) && i_rst_n;
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_o_valid || o_rsp.ready);
    assign mul_step    = (r_state == ST_MUL_D) || (r_state == ST_MUL_E);

    // shift-add multiply by 1e6, one constant bit per cycle, MSB first
    assign mul_next = (r_acc << 1) + (US_PER_S[r_bit] ?
        {{(ACC_W-MUL_X_W){r_mul_x[MUL_X_W-1]}}, r_mul_x} : ACC_W'(0));

    assign c_num = r_acc[E_W-1:0] + HALF_C;

    // negative sum means the time lies before the correction point
    assign e_sum = r_acc + {{(ACC_W-CYC_W){1'b0}}, r_us};
    assign e_val = e_sum[ACC_W-1] ? E_W'(0) : e_sum[E_W-1:0];

    assign pulse_us   = div_quo[CYC_W-1:0];
    assign pulse_done = (r_state == ST_DIV_C) && div_rsp.done && (r_req == REQ_PULSE);
    assign sec_next   = r_sec_cnt + ((pulse_us > MISSED_LIMIT_US) ? SEC_W'(2) : SEC_W'(1));

    ptk_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (div_req),
        .i_num   (div_num),
        .o_div   (div_rsp),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        div_req = '0;
        div_num = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if ((i_req.req_type == REQ_PULSE) ||
                        ((i_req.req_type == REQ_QUERY) && r_time_valid)) begin
                        n_state = ST_MUL_D;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MUL_D: begin
                if (r_bit == '0) begin
                    n_state = ST_DIV_C_GO;
                end
            end
            ST_DIV_C_GO: begin
                div_req.start = 1'b1;
                div_req.iters = ITER_C;
                div_req.den   = DEN_C;
                div_num       = {c_num, {(NUM_W-E_W){1'b0}}};
                n_state       = ST_DIV_C;
            end
            ST_DIV_C: begin
                if (div_rsp.done) begin
                    n_state = (r_req == REQ_PULSE) ? ST_DONE : ST_MUL_E;
                end
            end
            ST_MUL_E: begin
                if (r_bit == '0) begin
                    n_state = ST_DIV_R_GO;
                end
            end
            ST_DIV_R_GO: begin
                div_req.start = 1'b1;
                div_req.iters = ITER_R;
                div_req.den   = {{(DIV_DEN_W-RATIO_W){1'b0}}, r_freq_ratio};
                div_num       = {e_val, {(NUM_W-E_W){1'b0}}};
                n_state       = ST_DIV_R;
            end
            ST_DIV_R: begin
                if (div_rsp.done) begin
                    n_state = ST_DIV_U_GO;
                end
            end
            ST_DIV_U_GO: begin
                div_req.start = 1'b1;
                div_req.iters = ITER_U;
                div_req.den   = {{(DIV_DEN_W-US_W){1'b0}}, US_PER_S};
                div_num       = {div_quo[Q_W-1:0], {(NUM_W-Q_W){1'b0}}};
                n_state       = ST_DIV_U;
            end
            ST_DIV_U: begin
                if (div_rsp.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_ratio <= RATIO_ONE;
            r_corr_sec   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FREQ_RATIO: begin
                    if ((i_cfg_data[RATIO_W-1:0] >= RATIO_LO) &&
                        (i_cfg_data[RATIO_W-1:0] <= RATIO_HI)) begin
                        r_freq_ratio <= i_cfg_data[RATIO_W-1:0];
                    end
                end
                CFG_CORR_SEC: begin
                    r_corr_sec <= i_cfg_data[SEC_W-1:0];
                end
                default: begin
                    r_corr_sec <= r_corr_sec;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_cnt    <= '0;
            r_last_cyc   <= '0;
            r_time_valid <= 1'b0;
        end else begin
            if (in_acc && (i_req.req_type == REQ_SET)) begin
                r_sec_cnt    <= i_req.set_seconds;
                r_last_cyc   <= i_req.cycle_count;
                r_time_valid <= 1'b1;
            end
            // a double pulse leaves the time untouched
            if (pulse_done && (pulse_us >= DOUBLE_LIMIT_US)) begin
                r_sec_cnt  <= sec_next;
                r_last_cyc <= r_cyc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req        <= i_req.req_type;
            r_cyc        <= i_req.cycle_count;
            r_mul_x      <= {1'b0, i_req.cycle_count - r_last_cyc};
            r_acc        <= '0;
            r_bit        <= MUL_TOP;
            r_res_missed <= 1'b0;
            r_res_us     <= '0;
            r_res_sec    <= (i_req.req_type == REQ_SET) ? i_req.set_seconds : r_sec_cnt;
            r_res_status <= ((i_req.req_type == REQ_QUERY) && !r_time_valid) ?
                            STAT_NOT_SET : STAT_OK;
        end
        if (mul_step) begin
            r_acc <= mul_next;
            r_bit <= r_bit - MUL_BIT_W'(1);
        end
        if ((r_state == ST_DIV_C) && div_rsp.done) begin
            r_us    <= pulse_us;
            r_mul_x <= {1'b0, r_sec_cnt} - {1'b0, r_corr_sec};
            r_acc   <= '0;
            r_bit   <= MUL_TOP;
        end
        if (pulse_done) begin
            if (pulse_us < DOUBLE_LIMIT_US) begin
                r_res_status <= STAT_DOUBLE;
            end else begin
                r_res_missed <= (pulse_us > MISSED_LIMIT_US);
                r_res_sec    <= sec_next;
            end
        end
        if ((r_state == ST_DIV_U) && div_rsp.done) begin
            r_res_us  <= div_rsp.rem[US_W-1:0];
            r_res_sec <= div_quo[SEC_W-1:0] + r_corr_sec;
        end
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_missed <= r_res_missed;
            r_o_sec    <= r_res_sec;
            r_o_us     <= r_res_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.missed_pulse = r_o_missed;
    assign o_rsp.seconds      = r_o_sec;
    assign o_rsp.microseconds = r_o_us;

endmodule

`default_nettype wire

FILE: rtl/ptk_chk.sv
// Port-level checks of the time-of-day keeper's response word.
`default_nettype none

`include "pps_time_of_day_keeper_macros.svh"

module ptk_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [ptk_pkg::STAT_W-1:0] i_status,
    input wire logic                       i_missed,
    input wire logic [ptk_pkg::SEC_W-1:0]  i_seconds,
    input wire logic [ptk_pkg::US_W-1:0]   i_micro
);
    import ptk_pkg::*;

    `PTK_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_seconds) && $stable(i_micro) && $stable(i_status) && $stable(i_missed), "stalled response word changed")
    `PTK_ASSERT(a_err_clean, i_clk, i_rst_n, i_out_valid && (i_status != STAT_OK) |-> (i_micro == '0) && !i_missed, "error status with time fraction or missed flag")
    `PTK_ASSERT(a_missed_ok, i_clk, i_rst_n, i_out_valid && i_missed |-> (i_status == STAT_OK) && (i_micro == '0), "missed pulse flag on a non-pulse word")
    `PTK_ASSERT(a_us_range, i_clk, i_rst_n, i_out_valid |-> (i_micro < US_PER_S), "microseconds out of range")
    `PTK_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid, "response valid after reset")

endmodule

bind pps_time_of_day_keeper ptk_chk u_ptk_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_missed    (o_rsp.missed_pulse),
    .i_seconds   (o_rsp.seconds),
    .i_micro     (o_rsp.microseconds)
);

`default_nettype wire
